/* hdl/abbt_pkg.sv */
// ----------------------------------------------------------------------------
// Alpha bounding box trim package
// Shared widths, register indexes and the types passed between the
// bounding box tracker and the top level.
// ----------------------------------------------------------------------------
package abbt_pkg;

	localparam int ALPHA_W     = 8;
	localparam int CFG_W       = 13;
	localparam int OUT_W       = 13;
	localparam int CFG_IDX_W   = 1;
	localparam int DEF_MAX_DIM = 4096;
	localparam int DEF_SIZE    = 4096;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	typedef struct packed {
		logic advance;
		logic alpha_nz;
	} step_t;

	typedef struct packed {
		logic [OUT_W-1:0] margin_top;
		logic [OUT_W-1:0] margin_left;
		logic [OUT_W-1:0] margin_bottom;
		logic [OUT_W-1:0] margin_right;
		logic [OUT_W-1:0] trimmed_width;
		logic [OUT_W-1:0] trimmed_height;
		logic             empty_frame;
	} result_t;

endpackage

/* hdl/abbt_tracker.sv */
// ----------------------------------------------------------------------------
// Bounding box tracker
// Raster position counters, running bounding box of non-zero alpha, and
// the frame result formed on the last pixel.
// ----------------------------------------------------------------------------
module abbt_tracker #(
	parameter int CW = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  abbt_pkg::step_t   step,
	input  logic [CW-1:0]     last_col,
	input  logic [CW-1:0]     last_row,
	output logic              frame_end,
	output abbt_pkg::result_t res
);

	logic [CW-1:0] col_q, row_q;
	logic [CW-1:0] min_col_q, max_col_q, min_row_q, max_row_q;
	logic          seen_q;

	logic          at_last_col, at_last_row;
	logic          first_hit;
	logic          n_seen;
	logic [CW-1:0] n_min_col, n_max_col, n_min_row, n_max_row;
	logic [CW-1:0] mc, mr, nc, nr;
	logic [CW:0]   box_w, box_h;

	// A counter left beyond a shrunken size wraps as if it sat on the last position.
	assign at_last_col = (col_q >= last_col);
	assign at_last_row = (row_q >= last_row);
	assign frame_end   = at_last_col && at_last_row;

	assign first_hit = step.alpha_nz && !seen_q;
	assign n_seen    = seen_q || step.alpha_nz;

	always_comb begin
		n_min_col = min_col_q;
		n_max_col = max_col_q;
		n_min_row = min_row_q;
		n_max_row = max_row_q;
		if (first_hit) begin
			n_min_col = col_q;
			n_max_col = col_q;
			n_min_row = row_q;
			n_max_row = row_q;
		end else if (step.alpha_nz) begin
			if (col_q < min_col_q) n_min_col = col_q;
			if (col_q > max_col_q) n_max_col = col_q;
			if (row_q < min_row_q) n_min_row = row_q;
			if (row_q > max_row_q) n_max_row = row_q;
		end
	end

	// Clamp the box into the current frame size before forming the margins.
	always_comb begin
		mr = (n_max_row > last_row) ? last_row : n_max_row;
		mc = (n_max_col > last_col) ? last_col : n_max_col;
		nr = (n_min_row > mr) ? mr : n_min_row;
		nc = (n_min_col > mc) ? mc : n_min_col;
	end

	assign box_w = {1'b0, mc} - {1'b0, nc} + {{CW{1'b0}}, 1'b1};
	assign box_h = {1'b0, mr} - {1'b0, nr} + {{CW{1'b0}}, 1'b1};

	always_comb begin
		res = '0;
		res.empty_frame = !n_seen;
		if (n_seen) begin
			res.margin_top     = abbt_pkg::OUT_W'(nr);
			res.margin_left    = abbt_pkg::OUT_W'(nc);
			res.margin_bottom  = abbt_pkg::OUT_W'(last_row - mr);
			res.margin_right   = abbt_pkg::OUT_W'(last_col - mc);
			res.trimmed_width  = abbt_pkg::OUT_W'(box_w);
			res.trimmed_height = abbt_pkg::OUT_W'(box_h);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '0;
			max_col_q <= '0;
			min_row_q <= '0;
			max_row_q <= '0;
			seen_q    <= 1'b0;
		end else if (step.advance) begin
			if (frame_end) begin
				col_q     <= '0;
				row_q     <= '0;
				min_col_q <= '0;
				max_col_q <= '0;
				min_row_q <= '0;
				max_row_q <= '0;
				seen_q    <= 1'b0;
			end else begin
				if (at_last_col) begin
					col_q <= '0;
					row_q <= row_q + {{(CW-1){1'b0}}, 1'b1};
				end else begin
					col_q <= col_q + {{(CW-1){1'b0}}, 1'b1};
				end
				min_col_q <= n_min_col;
				max_col_q <= n_max_col;
				min_row_q <= n_min_row;
				max_row_q <= n_max_row;
				seen_q    <= n_seen;
			end
		end
	end

endmodule

/* hdl/alpha_bounding_box_trim_unit.sv */
// ----------------------------------------------------------------------------
// Alpha bounding box trim unit
// Finds the bounding box of non-zero alpha in a raster-order frame and
// reports the transparent margins and the trimmed size once per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Configure image_width (index 0) and image_height (index 1) through the
//   write port while the unit is idle. A size of zero acts as one, a size
//   above MAX_DIM acts as MAX_DIM. Both reset to 4096 (clamped to MAX_DIM).
//   Stream one alpha byte per transfer on the in_* channel, in raster order.
//   The unit takes one pixel per cycle while no last pixel is held. Each
//   pixel passes an input register before it is folded into the bounding
//   box, so the frame result is offered on the out_* channel once the last
//   pixel leaves the input register, and only then.
//   The result sits in an output register: pixels of the next frame keep
//   flowing while it waits. Only the last pixel of a frame stalls, in the
//   input register, while a previous result is still not taken.
//   An empty frame reports empty_frame with all sizes and margins zero.
//   Reset clears the position counters, the bounding box and the valid
//   flags of both pipeline stages, and restores the default frame size.
// ----------------------------------------------------------------------------
module alpha_bounding_box_trim_unit #(
	parameter int MAX_DIM = abbt_pkg::DEF_MAX_DIM
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [abbt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [abbt_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [abbt_pkg::ALPHA_W-1:0]   alpha,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [abbt_pkg::OUT_W-1:0]     margin_top,
	output logic [abbt_pkg::OUT_W-1:0]     margin_left,
	output logic [abbt_pkg::OUT_W-1:0]     margin_bottom,
	output logic [abbt_pkg::OUT_W-1:0]     margin_right,
	output logic [abbt_pkg::OUT_W-1:0]     trimmed_width,
	output logic [abbt_pkg::OUT_W-1:0]     trimmed_height,
	output logic                           empty_frame
);

	localparam int CW = $clog2(MAX_DIM);
	localparam int RESET_DIM =
		(abbt_pkg::DEF_SIZE > MAX_DIM) ? MAX_DIM : abbt_pkg::DEF_SIZE;
	localparam logic [CW-1:0] LAST_RESET = CW'(RESET_DIM - 1);
	localparam logic [CW-1:0] LAST_MAX   = CW'(MAX_DIM - 1);

	logic [CW-1:0]     last_col_q, last_row_q;
	logic [CW-1:0]     cfg_last;
	logic              valid_s1;
	logic              alpha_nz_s1;
	logic              advance;
	logic              frame_end;
	abbt_pkg::step_t   step;
	abbt_pkg::result_t res;
	abbt_pkg::result_t res_s2;
	logic              out_valid_s2;

	// Convert a written size into the last valid position index.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_last = '0;
		end else if (32'(cfg_data) > MAX_DIM) begin
			cfg_last = LAST_MAX;
		end else begin
			cfg_last = CW'(cfg_data - abbt_pkg::CFG_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= LAST_RESET;
			last_row_q <= LAST_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				abbt_pkg::REG_IMAGE_WIDTH:  last_col_q <= cfg_last;
				abbt_pkg::REG_IMAGE_HEIGHT: last_row_q <= cfg_last;
				default: ;
			endcase
		end
	end

	// Only a pixel that closes a frame needs room in the output register.
	assign advance  = valid_s1 && (!frame_end || !out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			alpha_nz_s1 <= (alpha != '0);
		end
	end

	assign step.advance  = advance;
	assign step.alpha_nz = alpha_nz_s1;

	abbt_tracker #(
		.CW(CW)
	) u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.last_col (last_col_q),
		.last_row (last_row_q),
		.frame_end(frame_end),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance && frame_end) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame_end) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = out_valid_s2;
	assign margin_top     = res_s2.margin_top;
	assign margin_left    = res_s2.margin_left;
	assign margin_bottom  = res_s2.margin_bottom;
	assign margin_right   = res_s2.margin_right;
	assign trimmed_width  = res_s2.trimmed_width;
	assign trimmed_height = res_s2.trimmed_height;
	assign empty_frame    = res_s2.empty_frame;

	// A frame that closes always leaves a result behind.
	a_frame_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && frame_end |=> out_valid)
		else $error("frame end did not produce a result");

	// Back pressure only ever comes from a held pixel behind a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled without a pending result");

	// An empty frame carries no box.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_frame |-> trimmed_width == '0 && trimmed_height == '0
			&& margin_top == '0 && margin_left == '0)
		else $error("empty frame with non-zero box");

	// Margins and the box span the full frame width when content was seen.
	a_width_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !empty_frame && !$changed(last_col_q) |->
			32'(margin_left) + 32'(trimmed_width) + 32'(margin_right)
				== 32'(last_col_q) + 32'd1)
		else $error("horizontal margins and width do not add up");

endmodule

/* test/tb_alpha_bounding_box_trim_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Alpha bounding box trim unit testbench
// Streams frames of alpha bytes through the unit at many frame sizes and
// checks every margin and trimmed size report against a cycle-free model
// of the bounding box tracker. Both handshake sides idle at random, the
// output is held off long enough to stall the input, and frame sizes are
// changed between frames and in the middle of a frame.
// ----------------------------------------------------------------------------
module tb_alpha_bounding_box_trim_unit;

	localparam int LONG_HOLD = 300;
	localparam logic [abbt_pkg::CFG_W-1:0] DIM_LIMIT =
		abbt_pkg::CFG_W'(abbt_pkg::DEF_MAX_DIM);

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_write = 1'b0;
	logic [abbt_pkg::CFG_IDX_W-1:0] cfg_index = abbt_pkg::REG_IMAGE_WIDTH;
	logic [abbt_pkg::CFG_W-1:0]     cfg_data  = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic [abbt_pkg::ALPHA_W-1:0]   alpha     = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [abbt_pkg::OUT_W-1:0]     margin_top;
	logic [abbt_pkg::OUT_W-1:0]     margin_left;
	logic [abbt_pkg::OUT_W-1:0]     margin_bottom;
	logic [abbt_pkg::OUT_W-1:0]     margin_right;
	logic [abbt_pkg::OUT_W-1:0]     trimmed_width;
	logic [abbt_pkg::OUT_W-1:0]     trimmed_height;
	logic                           empty_frame;

	alpha_bounding_box_trim_unit u_top (
		.clk,
		.arst_n,
		.cfg_write,
		.cfg_index,
		.cfg_data,
		.in_valid,
		.in_ready,
		.alpha,
		.out_valid,
		.out_ready,
		.margin_top,
		.margin_left,
		.margin_bottom,
		.margin_right,
		.trimmed_width,
		.trimmed_height,
		.empty_frame
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model of the tracker: size registers, position and bounding box.
	logic [abbt_pkg::CFG_W-1:0] width_reg  = abbt_pkg::CFG_W'(abbt_pkg::DEF_SIZE);
	logic [abbt_pkg::CFG_W-1:0] height_reg = abbt_pkg::CFG_W'(abbt_pkg::DEF_SIZE);
	logic [abbt_pkg::OUT_W-1:0] col_pos    = '0;
	logic [abbt_pkg::OUT_W-1:0] row_pos    = '0;
	logic [abbt_pkg::OUT_W-1:0] min_col    = '0;
	logic [abbt_pkg::OUT_W-1:0] max_col    = '0;
	logic [abbt_pkg::OUT_W-1:0] min_row    = '0;
	logic [abbt_pkg::OUT_W-1:0] max_row    = '0;
	logic                       seen       = 1'b0;

	abbt_pkg::result_t pending_boxes[$];
	bit                frame_closed;
	bit                quiet;
	bit                long_hold;
	int                pixels_sent;
	int                frames_sent;
	int                boxes_checked;
	int                empty_seen;
	int                error_count;

	function automatic logic [abbt_pkg::OUT_W-1:0] eff_size(
		input logic [abbt_pkg::CFG_W-1:0] value);
		if (value == '0) begin
			return abbt_pkg::OUT_W'(1);
		end else if (value > DIM_LIMIT) begin
			return DIM_LIMIT;
		end
		return value;
	endfunction

	function automatic void fold_pixel(input logic [abbt_pkg::ALPHA_W-1:0] value);
		logic [abbt_pkg::OUT_W-1:0] lc, lr, mr, mc, nr, nc;
		logic                       at_last_col, at_last_row;
		abbt_pkg::result_t          box;
		lc = eff_size(width_reg) - 1'b1;
		lr = eff_size(height_reg) - 1'b1;
		at_last_col = col_pos >= lc;
		at_last_row = row_pos >= lr;
		if (value != '0) begin
			if (!seen) begin
				min_col = col_pos;
				max_col = col_pos;
				min_row = row_pos;
				max_row = row_pos;
				seen    = 1'b1;
			end else begin
				if (col_pos < min_col) min_col = col_pos;
				if (col_pos > max_col) max_col = col_pos;
				if (row_pos < min_row) min_row = row_pos;
				if (row_pos > max_row) max_row = row_pos;
			end
		end
		frame_closed = 1'b0;
		if (!at_last_col) begin
			col_pos = col_pos + 1'b1;
		end else begin
			col_pos = '0;
			if (!at_last_row) begin
				row_pos = row_pos + 1'b1;
			end else begin
				box = '0;
				if (seen) begin
					// A box that was opened before a shrink is clipped to the new frame.
					mr = (max_row > lr) ? lr : max_row;
					mc = (max_col > lc) ? lc : max_col;
					nr = (min_row > mr) ? mr : min_row;
					nc = (min_col > mc) ? mc : min_col;
					box.margin_top     = nr;
					box.margin_left    = nc;
					box.margin_bottom  = lr - mr;
					box.margin_right   = lc - mc;
					box.trimmed_width  = mc - nc + 1'b1;
					box.trimmed_height = mr - nr + 1'b1;
				end else begin
					box.empty_frame = 1'b1;
				end
				pending_boxes.push_back(box);
				col_pos      = '0;
				row_pos      = '0;
				min_col      = '0;
				max_col      = '0;
				min_row      = '0;
				max_row      = '0;
				seen         = 1'b0;
				frame_closed = 1'b1;
				frames_sent++;
			end
		end
	endfunction

	function automatic string box_text(input abbt_pkg::result_t b);
		return $sformatf(
			"top=%0d left=%0d bottom=%0d right=%0d width=%0d height=%0d empty=%0b",
			b.margin_top, b.margin_left, b.margin_bottom, b.margin_right,
			b.trimmed_width, b.trimmed_height, b.empty_frame);
	endfunction

	// Results are sampled at the edge, before any nonblocking update lands.
	always @(posedge clk) begin : check_box
		abbt_pkg::result_t got;
		abbt_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {margin_top, margin_left, margin_bottom, margin_right,
				trimmed_width, trimmed_height, empty_frame};
			if (pending_boxes.size() == 0) begin
				if (error_count < 10) begin
					$display("%0t: result with no frame pending: %s", $realtime, box_text(got));
				end
				error_count++;
			end else begin
				want = pending_boxes.pop_front();
				boxes_checked++;
				if (want.empty_frame) empty_seen++;
				if (got.margin_top !== want.margin_top ||
						got.margin_left !== want.margin_left ||
						got.margin_bottom !== want.margin_bottom ||
						got.margin_right !== want.margin_right ||
						got.trimmed_width !== want.trimmed_width ||
						got.trimmed_height !== want.trimmed_height ||
						got.empty_frame !== want.empty_frame) begin
					if (error_count < 10) begin
						$display("%0t: frame %0d mismatch", $realtime, boxes_checked);
						$display("  expected %s", box_text(want));
						$display("  actual   %s", box_text(got));
					end
					error_count++;
				end
			end
		end
	end

	// Output side: random stalls, or one long hold-off when asked for.
	initial begin : drive_out_ready
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic push_pixel(input logic [abbt_pkg::ALPHA_W-1:0] value);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		alpha    <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		fold_pixel(value);
		pixels_sent++;
	endtask

	// Stops offering pixels and lets every pending result and the pipeline drain.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_boxes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_frame_size(input logic [abbt_pkg::CFG_W-1:0] w,
		input logic [abbt_pkg::CFG_W-1:0] h);
		cfg_write <= 1'b1;
		cfg_index <= abbt_pkg::REG_IMAGE_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= abbt_pkg::REG_IMAGE_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_write <= 1'b0;
		width_reg  = w;
		height_reg = h;
	endtask

	function automatic logic [abbt_pkg::CFG_W-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return '0;
		if (r <= 3) return abbt_pkg::CFG_W'($urandom_range(7, 16));
		return abbt_pkg::CFG_W'($urandom_range(1, 6));
	endfunction

	function automatic logic [abbt_pkg::ALPHA_W-1:0] random_alpha(input int density);
		if ($urandom_range(1, 8) <= density) begin
			return abbt_pkg::ALPHA_W'($urandom_range(1, 255));
		end
		return '0;
	endfunction

	task automatic test_corner_cases();
		wait_idle();
		set_frame_size(13'd2, 13'd2);
		push_pixel(8'h00); push_pixel(8'h00); push_pixel(8'h00); push_pixel(8'h00);
		push_pixel(8'hFF); push_pixel(8'hFF); push_pixel(8'hFF); push_pixel(8'hFF);
		push_pixel(8'h01); push_pixel(8'h00); push_pixel(8'h00); push_pixel(8'h00);
		push_pixel(8'h00); push_pixel(8'h00); push_pixel(8'h00); push_pixel(8'h80);
		wait_idle();
		set_frame_size(13'd1, 13'd1);
		push_pixel(8'hFF);
		wait_idle();
		// A size of zero behaves as a single pixel.
		set_frame_size(13'd0, 13'd0);
		push_pixel(8'h00);
	endtask

	task automatic test_resize_mid_frame();
		wait_idle();
		set_frame_size(13'd4, 13'd4);
		push_pixel(8'h00); push_pixel(8'h00); push_pixel(8'h7F); push_pixel(8'h00);
		push_pixel(8'h00); push_pixel(8'h00);
		// The column counter now lies past the new last column.
		wait_idle();
		set_frame_size(13'd2, 13'd2);
		push_pixel(8'h10);
		push_pixel(8'h00); push_pixel(8'h00); push_pixel(8'h00); push_pixel(8'h40);
		wait_idle();
		set_frame_size(13'd3, 13'd5);
		for (int i = 0; i < 9; i++) push_pixel((i == 7) ? 8'h22 : 8'h00);
		// Now the row counter lies past the new last row.
		wait_idle();
		set_frame_size(13'd3, 13'd2);
		push_pixel(8'h00); push_pixel(8'h00); push_pixel(8'h00);
	endtask

	// Frames are opened at the largest and over-range sizes and closed early
	// by shrinking, so the counters run far past small sizes without a full frame.
	task automatic test_largest_sizes();
		wait_idle();
		set_frame_size(13'd8191, 13'd1);
		for (int i = 0; i < 100; i++) push_pixel((i == 0 || i == 99) ? 8'hFF : 8'h00);
		wait_idle();
		set_frame_size(13'd100, 13'd1);
		push_pixel(8'h00);
		wait_idle();
		set_frame_size(13'd1, 13'd8191);
		for (int i = 0; i < 60; i++) push_pixel((i == 30) ? 8'h5A : 8'h00);
		wait_idle();
		set_frame_size(13'd1, 13'd60);
		push_pixel(8'h00);
		wait_idle();
		set_frame_size(DIM_LIMIT, 13'd2);
		for (int i = 0; i < 50; i++) push_pixel((i == 10 || i == 45) ? 8'hC3 : 8'h00);
		// The box reaches beyond the new width and is clipped at the frame end.
		wait_idle();
		set_frame_size(13'd30, 13'd2);
		for (int i = 0; i < 30; i++) push_pixel(8'h00);
		wait_idle();
		set_frame_size(13'd0, 13'd4097);
		for (int i = 0; i < 40; i++) push_pixel(8'h00);
		wait_idle();
		set_frame_size(13'd1, 13'd20);
		push_pixel(8'h00);
	endtask

	task automatic test_output_backpressure();
		wait_idle();
		set_frame_size(13'd1, 13'd1);
		long_hold = 1'b1;
		// Every pixel closes a frame, so the unit fills up behind the held output.
		for (int i = 0; i < 16; i++) push_pixel(random_alpha(4));
		wait_idle();
		for (int i = 0; i < 8; i++) push_pixel(random_alpha(4));
	endtask

	task automatic run_random_frames(input int pixel_goal, input int frame_goal);
		int start_pixels, start_frames, density, cut, count;
		start_pixels = pixels_sent;
		start_frames = frames_sent;
		while (pixels_sent - start_pixels < pixel_goal ||
				frames_sent - start_frames < frame_goal) begin
			if ($urandom_range(0, 1) == 0) begin
				wait_idle();
				set_frame_size(pick_dim(), pick_dim());
			end
			case ($urandom_range(0, 5))
				0: density = 0;
				1: density = 8;
				2: density = 4;
				default: density = 1;
			endcase
			cut   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30) : -1;
			count = 0;
			frame_closed = 1'b0;
			while (!frame_closed) begin
				if (count == cut) begin
					wait_idle();
					if ($urandom_range(0, 1) == 0) set_frame_size(pick_dim(), pick_dim());
				end
				push_pixel(random_alpha(density));
				count++;
			end
		end
	endtask

	task automatic test_random_frames();
		run_random_frames(900, 40);
	endtask

	task automatic test_steady_stream();
		quiet = 1'b1;
		run_random_frames(150, 5);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		test_resize_mid_frame();
		test_largest_sizes();
		test_output_backpressure();
		test_random_frames();
		test_steady_stream();
		wait_idle();
		repeat (8) @(posedge clk);
		if (pending_boxes.size() != 0) begin
			$display("%0d frame results never arrived", pending_boxes.size());
			error_count++;
		end
		$display("Sent %0d pixels in %0d frames, checked %0d reports (%0d empty).",
			pixels_sent, frames_sent, boxes_checked, empty_seen);
		$display("Sizes from one pixel up to clamped 4096 settings, resized between and within frames.");
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d frame results pending", pending_boxes.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
